// ===== src/pqbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pqbp_pkg
// Shared types, constants and distance helpers for the palette quantizer
// and bit-plane packer.
// ----------------------------------------------------------------------------
package pqbp_pkg;

  // field and datapath widths
  localparam int PIXEL_W         = 24;
  localparam int CHAN_W          = 8;
  localparam int BYTE_W          = 8;
  localparam int PALETTE_ENTRIES = 4;
  localparam int PIXELS_PER_BYTE = 8;
  localparam int IDX_W           = 2;
  localparam int POS_W           = 3;
  localparam int MODE_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int SQ_W            = 2 * CHAN_W;
  localparam int DIST_W          = SQ_W + 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_SELECT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 3'd6;

  // packing modes; the unused code behaves as masked
  localparam logic [MODE_W-1:0] MODE_BOTH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MASKED = 2'd2;

  localparam logic [PIXEL_W-1:0] KEY_COLOR_RESET = 24'hFF00FF;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [PALETTE_ENTRIES-1:0][PIXEL_W-1:0] palette_t;

  // per-pixel result of the distance stage
  typedef struct packed {
    logic [PALETTE_ENTRIES-1:0][DIST_W-1:0] sq_dist;
    logic                                   key_hit;
  } dist_info_t;

  // squared difference of one channel
  function automatic logic [SQ_W-1:0] chan_sq(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return SQ_W'(diff) * SQ_W'(diff);
  endfunction

  // squared euclidean distance over the three channels
  function automatic logic [DIST_W-1:0] color_dist(input pixel_t p, input pixel_t q);
    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] g_sq;
    logic [SQ_W-1:0] b_sq;
    r_sq = chan_sq(p[CHAN_W-1:0], q[CHAN_W-1:0]);
    g_sq = chan_sq(p[2*CHAN_W-1:CHAN_W], q[2*CHAN_W-1:CHAN_W]);
    b_sq = chan_sq(p[3*CHAN_W-1:2*CHAN_W], q[3*CHAN_W-1:2*CHAN_W]);
    return DIST_W'(r_sq) + DIST_W'(g_sq) + DIST_W'(b_sq);
  endfunction

endpackage

// ===== src/pqbp_dist.sv =====
// ----------------------------------------------------------------------------
// pqbp_dist
// Pixel input register followed by a register holding the four palette
// distances and the key color match.
// ----------------------------------------------------------------------------
module pqbp_dist import pqbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pixel_t     pixel,
  input  palette_t   palette,
  input  pixel_t     key_color,
  output logic       out_valid,
  input  logic       out_ready,
  output dist_info_t out_info
);

  logic       pix_valid;
  pixel_t     pix_reg;
  logic       pix_ready;
  logic       dist_ready;
  dist_info_t info_next;

  // stage enables
  assign dist_ready = !out_valid || out_ready;
  assign pix_ready  = !pix_valid || dist_ready;
  assign in_ready   = pix_ready;

  // pixel register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pix_ready) begin
      pix_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && in_valid) begin
      pix_reg <= pixel;
    end
  end

  // four distances in parallel, plus key match
  always_comb begin
    for (int k = 0; k < PALETTE_ENTRIES; k++) begin
      info_next.sq_dist[k] = color_dist(palette[k], pix_reg);
    end
    info_next.key_hit = (pix_reg == key_color);
  end

  // distance register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dist_ready) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_ready && pix_valid) begin
      out_info <= info_next;
    end
  end

endmodule

// ===== src/pqbp_pack.sv =====
// ----------------------------------------------------------------------------
// pqbp_pack
// Picks the nearest palette index, shifts its bits into the byte
// accumulators and holds each finished byte pair in the result register.
// ----------------------------------------------------------------------------
module pqbp_pack import pqbp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dist_info_t        in_info,
  input  logic [MODE_W-1:0] pack_mode,
  input  logic              plane_select,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] first_byte,
  output logic [BYTE_W-1:0] second_byte
);

  logic [POS_W-1:0]  pixel_count;
  logic [BYTE_W-1:0] first_accum;
  logic [BYTE_W-1:0] second_accum;
  logic [BYTE_W-1:0] first_accum_next;
  logic [BYTE_W-1:0] second_accum_next;
  logic [BYTE_W-1:0] pos_mask;
  logic [IDX_W-1:0]  lo_idx;
  logic [IDX_W-1:0]  hi_idx;
  logic [DIST_W-1:0] lo_dist;
  logic [DIST_W-1:0] hi_dist;
  logic [IDX_W-1:0]  idx;
  logic              sel;
  logic              first_bit;
  logic              second_bit;
  logic              take;
  logic              last;

  // nearest entry, lower index wins ties
  always_comb begin
    if (in_info.sq_dist[1] < in_info.sq_dist[0]) begin
      lo_idx  = IDX_W'(1);
      lo_dist = in_info.sq_dist[1];
    end else begin
      lo_idx  = IDX_W'(0);
      lo_dist = in_info.sq_dist[0];
    end
    if (in_info.sq_dist[3] < in_info.sq_dist[2]) begin
      hi_idx  = IDX_W'(3);
      hi_dist = in_info.sq_dist[3];
    end else begin
      hi_idx  = IDX_W'(2);
      hi_dist = in_info.sq_dist[2];
    end
    idx = (hi_dist < lo_dist) ? hi_idx : lo_idx;
  end

  assign sel = idx[plane_select];

  // bits contributed by this pixel
  always_comb begin
    first_bit  = 1'b0;
    second_bit = 1'b0;
    case (pack_mode)
      MODE_BOTH: begin
        first_bit  = idx[0];
        second_bit = idx[1];
      end
      MODE_SINGLE: begin
        first_bit  = sel;
      end
      default: begin
        first_bit  = in_info.key_hit;
        second_bit = !in_info.key_hit && sel;
      end
    endcase
  end

  // first pixel of a byte lands in the msb
  assign pos_mask          = BYTE_W'(8'h80) >> pixel_count;
  assign first_accum_next  = first_accum | (first_bit ? pos_mask : '0);
  assign second_accum_next = second_accum | (second_bit ? pos_mask : '0);

  assign last     = (pixel_count == POS_W'(PIXELS_PER_BYTE - 1));
  assign in_ready = !last || !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // accumulators, pixel count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count  <= '0;
      first_accum  <= '0;
      second_accum <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (last) begin
          out_valid    <= 1'b1;
          pixel_count  <= '0;
          first_accum  <= '0;
          second_accum <= '0;
        end else begin
          pixel_count  <= pixel_count + POS_W'(1);
          first_accum  <= first_accum_next;
          second_accum <= second_accum_next;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && last) begin
      first_byte  <= first_accum_next;
      second_byte <= second_accum_next;
    end
  end

  // bits not yet reached in the current byte stay clear
  a_first_low_clear: assert property (@(posedge clk) disable iff (rst)
    (first_accum & (BYTE_W'(8'hFF) >> pixel_count)) == '0)
    else $error("first accumulator has bits beyond the current position");

  a_second_low_clear: assert property (@(posedge clk) disable iff (rst)
    (second_accum & (BYTE_W'(8'hFF) >> pixel_count)) == '0)
    else $error("second accumulator has bits beyond the current position");

  // a completed byte always shows up as a result
  a_last_loads_out: assert property (@(posedge clk) disable iff (rst)
    take && last |=> out_valid && pixel_count == '0)
    else $error("completed byte did not reach the result register");

  // input stalls only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && last)
    else $error("pixel stalled without a blocked result");

  // a key pixel in masked mode never sets a color bit
  a_key_no_color: assert property (@(posedge clk) disable iff (rst)
    take && !last && pack_mode[1] && in_info.key_hit |=>
      second_accum == $past(second_accum))
    else $error("key pixel set a color bit");

endmodule

// ===== src/palette_quantize_bitplane_pack.sv =====
// ----------------------------------------------------------------------------
// palette_quantize_bitplane_pack
// Maps each RGB pixel to the nearest of four palette colors and packs the
// index or key-match bits of eight pixels into a pair of bit-plane bytes.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock unless a full result register is stalled
//   by m_axis_tready; one result per eight pixels. m_axis_tvalid rises once
//   the eighth pixel has passed the pixel, distance and result registers.
// The distance register holds the four parallel squared-distance sums.
// Reset (rst, synchronous): pipeline empty, pixel count and accumulators
//   zero, palette zero, mode both planes, plane 0, key color 0xFF00FF.
module palette_quantize_bitplane_pack import pqbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PIXEL_W-1:0]   s_axis_tdata,   // [23:0] pixel_color
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*BYTE_W-1:0]  m_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIXEL_W-1:0]   cfg_wdata
);

  palette_t          palette;
  logic [MODE_W-1:0] pack_mode;
  logic              plane_select;
  pixel_t            key_color;

  logic              dist_valid;
  logic              dist_ready;
  dist_info_t        dist_info;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      palette      <= '0;
      pack_mode    <= MODE_BOTH;
      plane_select <= 1'b0;
      key_color    <= KEY_COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PALETTE_0:    palette[0]   <= cfg_wdata;
        REG_PALETTE_1:    palette[1]   <= cfg_wdata;
        REG_PALETTE_2:    palette[2]   <= cfg_wdata;
        REG_PALETTE_3:    palette[3]   <= cfg_wdata;
        REG_PACK_MODE:    pack_mode    <= cfg_wdata[MODE_W-1:0];
        REG_PLANE_SELECT: plane_select <= cfg_wdata[0];
        REG_KEY_COLOR:    key_color    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // distance stages
  pqbp_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .pixel     (s_axis_tdata),
    .palette   (palette),
    .key_color (key_color),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .out_info  (dist_info)
  );

  // index selection, packing and result register
  pqbp_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dist_valid),
    .in_ready     (dist_ready),
    .in_info      (dist_info),
    .pack_mode    (pack_mode),
    .plane_select (plane_select),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .first_byte   (first_byte),
    .second_byte  (second_byte)
  );

  assign m_axis_tdata = {second_byte, first_byte};

endmodule
